[sv/htm_pkg.sv]
// Shared types, constants and corner table for the hexahedron trilinear mapper.
`timescale 1ns / 1ps

package htm_pkg;

	localparam int CoordW = 32;
	localparam int LocalW = 17;
	localparam int OpAW   = 34;
	localparam int OpBW   = 25;
	localparam int ProdW  = 60;
	localparam int AccW   = 82;
	localparam int WtW    = 49;
	localparam int HiShift = 25;

	localparam logic [LocalW-1:0] OneQ16 = 17'd65536;

	// Rounding offset: half of one output LSB at scale 2^48.
	localparam logic signed [AccW-1:0] AccInit = 82'sd1 <<< 47;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] COORD_X = 2'd0;
	localparam logic [1:0] COORD_Y = 2'd1;
	localparam logic [1:0] COORD_Z = 2'd2;

	localparam logic [2:0] STEP_UV  = 3'd0;
	localparam logic [2:0] STEP_W   = 3'd1;
	localparam logic [2:0] STEP_XLO = 3'd2;
	localparam logic [2:0] STEP_XHI = 3'd3;
	localparam logic [2:0] STEP_YLO = 3'd4;
	localparam logic [2:0] STEP_YHI = 3'd5;
	localparam logic [2:0] STEP_ZLO = 3'd6;
	localparam logic [2:0] STEP_ZHI = 3'd7;

	// Corner flags in hex order: bit 0 u, bit 1 v, bit 2 w.
	localparam logic [2:0] HexFlags [8] = '{
		3'b000, 3'b001, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b111, 3'b110
	};

	typedef struct packed {
		logic       vld;
		logic [1:0] coord;
		logic       hi;
	} acc_tag_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

endpackage

[sv/hex_trilinear_map.sv]
// Top level of the hexahedron trilinear mapper: corner ring, sequencer, MAC.
// Usage:
//   Command port: a transfer happens at a rising edge with start high and busy
//   low. command selects a corner load or an evaluate.
//   A load writes corner corner_slot from load_x/y/z at the transfer edge,
//   gives no result and leaves busy low, so loads may follow one another
//   every cycle. An evaluate raises busy. Eight corner cells form a ring that
//   rotates one place per corner past a single shared 34x25 multiplier; each
//   corner runs through the steps u*v, times w, then low and high weight
//   halves for x, y and z. A drain state and an output state follow; the
//   result appears on point_x/y/z with done high in the same cycle that busy
//   falls, and the next command can be accepted from then on.
//   The done strobe is high for exactly one cycle; the receiver cannot stall it.
//   Reset (arst_n low) clears all eight corners to zero and returns to idle.
`timescale 1ns / 1ps

module hex_trilinear_map (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic        [2:0]                  corner_slot,
	input  logic signed [htm_pkg::CoordW-1:0] load_x,
	input  logic signed [htm_pkg::CoordW-1:0] load_y,
	input  logic signed [htm_pkg::CoordW-1:0] load_z,
	input  logic        [htm_pkg::LocalW-1:0] local_u,
	input  logic        [htm_pkg::LocalW-1:0] local_v,
	input  logic        [htm_pkg::LocalW-1:0] local_w,
	output logic                               done,
	output logic signed [htm_pkg::CoordW-1:0] point_x,
	output logic signed [htm_pkg::CoordW-1:0] point_y,
	output logic signed [htm_pkg::CoordW-1:0] point_z
);

	htm_pkg::state_t state_q;
	logic [2:0] step_q;
	logic [2:0] cnt_q;
	logic [htm_pkg::LocalW-1:0] tu_q, tv_q, tw_q;
	logic [htm_pkg::WtW-1:0]    w_q;
	logic done_q;
	logic signed [htm_pkg::CoordW-1:0] px_q, py_q, pz_q;

	logic accept, load_acc, eval_acc, shift_en, run;
	logic signed [htm_pkg::CoordW-1:0] cx [8];
	logic signed [htm_pkg::CoordW-1:0] cy [8];
	logic signed [htm_pkg::CoordW-1:0] cz [8];
	logic [2:0] flags;
	logic [htm_pkg::LocalW-1:0] fu, fv, fw;
	logic [htm_pkg::WtW-1:0] w_cur;
	logic signed [htm_pkg::CoordW-1:0] head;
	logic signed [htm_pkg::OpAW-1:0] op_a;
	logic [htm_pkg::OpBW-1:0] op_b;
	htm_pkg::acc_tag_t tag;
	logic signed [htm_pkg::ProdW-1:0] prod;
	logic signed [htm_pkg::AccW-1:0] acc_x, acc_y, acc_z;

	function automatic logic [htm_pkg::LocalW-1:0] clamp_t(input logic [htm_pkg::LocalW-1:0] t);
		clamp_t = (t > htm_pkg::OneQ16) ? htm_pkg::OneQ16 : t;
	endfunction

	function automatic logic signed [htm_pkg::CoordW-1:0] sat_out(
		input logic signed [htm_pkg::AccW-1:0] acc
	);
		logic signed [htm_pkg::AccW-htm_pkg::WtW:0] r;
		r = acc[htm_pkg::AccW-1:htm_pkg::WtW-1];
		if (r > $signed({{(htm_pkg::AccW-htm_pkg::WtW-htm_pkg::CoordW+1){1'b0}},
				{1'b0, {(htm_pkg::CoordW-1){1'b1}}}}))
			sat_out = {1'b0, {(htm_pkg::CoordW-1){1'b1}}};
		else if (r < $signed({{(htm_pkg::AccW-htm_pkg::WtW-htm_pkg::CoordW+1){1'b1}},
				{1'b1, {(htm_pkg::CoordW-1){1'b0}}}}))
			sat_out = {1'b1, {(htm_pkg::CoordW-1){1'b0}}};
		else
			sat_out = r[htm_pkg::CoordW-1:0];
	endfunction

	assign busy     = (state_q != htm_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign load_acc = accept && (command == htm_pkg::CMD_LOAD);
	assign eval_acc = accept && (command == htm_pkg::CMD_EVAL);
	assign run      = (state_q == htm_pkg::ST_RUN);
	// Rotate the ring once per corner, after its last product.
	assign shift_en = run && (step_q == htm_pkg::STEP_ZHI);

	for (genvar i = 0; i < 8; i++) begin : g_cell
		htm_corner_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (load_acc && (corner_slot == 3'(i))),
			.load_x   (load_x),
			.load_y   (load_y),
			.load_z   (load_z),
			.shift_en (shift_en),
			.nbr_x    (cx[(i + 1) % 8]),
			.nbr_y    (cy[(i + 1) % 8]),
			.nbr_z    (cz[(i + 1) % 8]),
			.cx       (cx[i]),
			.cy       (cy[i]),
			.cz       (cz[i])
		);
	end

	assign flags = htm_pkg::HexFlags[cnt_q];
	assign fu = flags[0] ? tu_q : htm_pkg::OneQ16 - tu_q;
	assign fv = flags[1] ? tv_q : htm_pkg::OneQ16 - tv_q;
	assign fw = flags[2] ? tw_q : htm_pkg::OneQ16 - tw_q;

	// The full weight leaves the multiplier during the first coordinate step.
	assign w_cur = (step_q == htm_pkg::STEP_XLO) ? prod[htm_pkg::WtW-1:0] : w_q;

	always_comb begin
		head = cx[0];
		op_a = htm_pkg::OpAW'(fu);
		op_b = htm_pkg::OpBW'(fv);
		tag  = '0;
		case (step_q)
			htm_pkg::STEP_UV: begin
				op_a = htm_pkg::OpAW'(fu);
				op_b = htm_pkg::OpBW'(fv);
			end
			htm_pkg::STEP_W: begin
				op_a = $signed({1'b0, prod[htm_pkg::OpAW-2:0]});
				op_b = htm_pkg::OpBW'(fw);
			end
			htm_pkg::STEP_XLO, htm_pkg::STEP_XHI: begin
				head = cx[0];
				tag.coord = htm_pkg::COORD_X;
			end
			htm_pkg::STEP_YLO, htm_pkg::STEP_YHI: begin
				head = cy[0];
				tag.coord = htm_pkg::COORD_Y;
			end
			htm_pkg::STEP_ZLO, htm_pkg::STEP_ZHI: begin
				head = cz[0];
				tag.coord = htm_pkg::COORD_Z;
			end
			default: begin
				tag = '0;
			end
		endcase
		if (step_q inside {[htm_pkg::STEP_XLO:htm_pkg::STEP_ZHI]}) begin
			op_a   = htm_pkg::OpAW'(head);
			tag.hi = step_q[0];
			op_b   = step_q[0] ? htm_pkg::OpBW'(w_cur[htm_pkg::WtW-1:htm_pkg::HiShift])
				: w_cur[htm_pkg::OpBW-1:0];
			tag.vld = run;
		end
	end

	htm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (eval_acc),
		.op_a   (op_a),
		.op_b   (op_b),
		.tag    (tag),
		.prod   (prod),
		.acc_x  (acc_x),
		.acc_y  (acc_y),
		.acc_z  (acc_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htm_pkg::ST_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				htm_pkg::ST_IDLE: begin
					if (eval_acc) state_q <= htm_pkg::ST_RUN;
				end
				htm_pkg::ST_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == htm_pkg::STEP_ZHI) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd7) state_q <= htm_pkg::ST_DRAIN;
					end
				end
				htm_pkg::ST_DRAIN: begin
					state_q <= htm_pkg::ST_OUT;
				end
				htm_pkg::ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= htm_pkg::ST_IDLE;
				end
				default: begin
					state_q <= htm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			tu_q <= clamp_t(local_u);
			tv_q <= clamp_t(local_v);
			tw_q <= clamp_t(local_w);
		end
		if (run && (step_q == htm_pkg::STEP_XLO)) w_q <= prod[htm_pkg::WtW-1:0];
		if (state_q == htm_pkg::ST_OUT) begin
			px_q <= sat_out(acc_x);
			py_q <= sat_out(acc_y);
			pz_q <= sat_out(acc_z);
		end
	end

	assign done    = done_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign point_z = pz_q;

	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htm_pkg::ST_IDLE) |-> (step_q == 3'd0 && cnt_q == 3'd0))
		else $error("corner ring not at home while idle");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eval_acc |=> busy)
		else $error("evaluate transfer did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(state_q == htm_pkg::ST_OUT)))
		else $error("result strobe outside the output step");

	a_drain_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htm_pkg::ST_DRAIN) |-> $past(shift_en) && cnt_q == 3'd0)
		else $error("drain entered before the last corner");

endmodule

[sv/htm_corner_cell.sv]
// One corner cell of the rotating corner ring.
`timescale 1ns / 1ps

module htm_corner_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load_en,
	input  logic signed [htm_pkg::CoordW-1:0] load_x,
	input  logic signed [htm_pkg::CoordW-1:0] load_y,
	input  logic signed [htm_pkg::CoordW-1:0] load_z,
	input  logic                               shift_en,
	input  logic signed [htm_pkg::CoordW-1:0] nbr_x,
	input  logic signed [htm_pkg::CoordW-1:0] nbr_y,
	input  logic signed [htm_pkg::CoordW-1:0] nbr_z,
	output logic signed [htm_pkg::CoordW-1:0] cx,
	output logic signed [htm_pkg::CoordW-1:0] cy,
	output logic signed [htm_pkg::CoordW-1:0] cz
);

	logic signed [htm_pkg::CoordW-1:0] x_q, y_q, z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (load_en) begin
			x_q <= load_x;
			y_q <= load_y;
			z_q <= load_z;
		end else if (shift_en) begin
			x_q <= nbr_x;
			y_q <= nbr_y;
			z_q <= nbr_z;
		end
	end

	assign cx = x_q;
	assign cy = y_q;
	assign cz = z_q;

endmodule

[sv/htm_mac.sv]
// Shared multiplier with registered product and three exact accumulators.
`timescale 1ns / 1ps

module htm_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  logic signed [htm_pkg::OpAW-1:0]    op_a,
	input  logic        [htm_pkg::OpBW-1:0]    op_b,
	input  htm_pkg::acc_tag_t                   tag,
	output logic signed [htm_pkg::ProdW-1:0]   prod,
	output logic signed [htm_pkg::AccW-1:0]    acc_x,
	output logic signed [htm_pkg::AccW-1:0]    acc_y,
	output logic signed [htm_pkg::AccW-1:0]    acc_z
);

	logic signed [htm_pkg::ProdW-1:0] prod_s1;
	htm_pkg::acc_tag_t                tag_s1;
	logic signed [htm_pkg::AccW-1:0]  acc_q [3];
	logic signed [htm_pkg::AccW-1:0]  prod_ext;
	logic signed [htm_pkg::AccW-1:0]  addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * $signed({1'b0, op_b});
	end

	assign prod_ext = htm_pkg::AccW'(prod_s1);
	// High half of the weight sits 25 bits up.
	assign addend   = tag_s1.hi ? (prod_ext <<< htm_pkg::HiShift) : prod_ext;

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q[0] <= htm_pkg::AccInit;
			acc_q[1] <= htm_pkg::AccInit;
			acc_q[2] <= htm_pkg::AccInit;
		end else if (tag_s1.vld) begin
			acc_q[tag_s1.coord] <= acc_q[tag_s1.coord] + addend;
		end
	end

	assign prod  = prod_s1;
	assign acc_x = acc_q[htm_pkg::COORD_X];
	assign acc_y = acc_q[htm_pkg::COORD_Y];
	assign acc_z = acc_q[htm_pkg::COORD_Z];

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the hexahedron trilinear mapper.
`timescale 1ns / 1ps

module tb_top;

	localparam int ITEM_TOTAL   = 800;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_PCT [4] = '{0, 86, 0, 35};

	// Corner flags in hex order: bit 0 u, bit 1 v, bit 2 w.
	localparam logic [2:0] CORNER_BITS [8] = '{
		3'b000, 3'b001, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b111, 3'b110
	};

	localparam logic signed [99:0] SAT_HI = 100'sd2147483647;
	localparam logic signed [99:0] SAT_LO = -SAT_HI - 100'sd1;
	localparam logic signed [99:0] HALF_LSB = 100'sd1 <<< 47;

	typedef struct {
		logic                              cmd;
		logic [2:0]                        slot;
		logic signed [htm_pkg::CoordW-1:0] x, y, z;
		logic [htm_pkg::LocalW-1:0]        u, v, w;
		int                                idle_pct;
	} mapper_cmd_t;

	typedef struct {
		logic signed [htm_pkg::CoordW-1:0] x, y, z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic command = htm_pkg::CMD_LOAD;
	logic [2:0] corner_slot = '0;
	logic signed [htm_pkg::CoordW-1:0] load_x = '0;
	logic signed [htm_pkg::CoordW-1:0] load_y = '0;
	logic signed [htm_pkg::CoordW-1:0] load_z = '0;
	logic [htm_pkg::LocalW-1:0] local_u = '0;
	logic [htm_pkg::LocalW-1:0] local_v = '0;
	logic [htm_pkg::LocalW-1:0] local_w = '0;
	logic busy;
	logic done;
	logic signed [htm_pkg::CoordW-1:0] point_x;
	logic signed [htm_pkg::CoordW-1:0] point_y;
	logic signed [htm_pkg::CoordW-1:0] point_z;

	mapper_cmd_t cmd_q [$];
	point_t      point_q [$];

	logic signed [htm_pkg::CoordW-1:0] hex_x [8] = '{default: '0};
	logic signed [htm_pkg::CoordW-1:0] hex_y [8] = '{default: '0};
	logic signed [htm_pkg::CoordW-1:0] hex_z [8] = '{default: '0};

	int error_count = 0;
	int stall_cycles = 0;

	hex_trilinear_map u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.corner_slot (corner_slot),
		.load_x      (load_x),
		.load_y      (load_y),
		.load_z      (load_z),
		.local_u     (local_u),
		.local_v     (local_v),
		.local_w     (local_w),
		.done        (done),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [htm_pkg::CoordW-1:0] blend_axis(
		input logic signed [htm_pkg::CoordW-1:0] cs [8],
		input logic [48:0] wt [8]
	);
		logic signed [99:0] acc;
		logic signed [99:0] c_ext;
		logic signed [99:0] w_ext;
		acc = '0;
		for (int n = 0; n < 8; n++) begin
			c_ext = cs[n];
			w_ext = {51'd0, wt[n]};
			acc = acc + c_ext * w_ext;
		end
		// round half up, then back to Q16.16
		acc = (acc + HALF_LSB) >>> 48;
		if (acc > SAT_HI)
			acc = SAT_HI;
		if (acc < SAT_LO)
			acc = SAT_LO;
		return acc[htm_pkg::CoordW-1:0];
	endfunction

	function automatic point_t map_point(input logic [htm_pkg::LocalW-1:0] u, v, w);
		logic [htm_pkg::LocalW-1:0] t [3];
		logic [htm_pkg::LocalW-1:0] f [3];
		logic [48:0] wt [8];
		point_t p;
		t[0] = (u > htm_pkg::OneQ16) ? htm_pkg::OneQ16 : u;
		t[1] = (v > htm_pkg::OneQ16) ? htm_pkg::OneQ16 : v;
		t[2] = (w > htm_pkg::OneQ16) ? htm_pkg::OneQ16 : w;
		for (int n = 0; n < 8; n++) begin
			for (int k = 0; k < 3; k++)
				f[k] = CORNER_BITS[n][k] ? t[k] : htm_pkg::OneQ16 - t[k];
			wt[n] = 49'(f[0]) * 49'(f[1]) * 49'(f[2]);
		end
		p.x = blend_axis(hex_x, wt);
		p.y = blend_axis(hex_y, wt);
		p.z = blend_axis(hex_z, wt);
		return p;
	endfunction

	function automatic logic signed [htm_pkg::CoordW-1:0] rand_coord();
		logic signed [htm_pkg::CoordW-1:0] c;
		case ($urandom_range(0, 3))
			0: c = 32'($urandom_range(0, 1 << 20)) - 32'sd524288;
			1: begin
				case ($urandom_range(0, 4))
					0: c = 32'sh7fffffff;
					1: c = 32'sh80000000;
					2: c = 32'sh00000000;
					3: c = 32'shffffffff;
					default: c = 32'sh00000001;
				endcase
			end
			default: c = $urandom;
		endcase
		return c;
	endfunction

	function automatic logic [htm_pkg::LocalW-1:0] rand_local();
		logic [htm_pkg::LocalW-1:0] t;
		case ($urandom_range(0, 7))
			6: begin
				case ($urandom_range(0, 4))
					0: t = '0;
					1: t = 17'd1;
					2: t = 17'd32768;
					3: t = 17'd65535;
					default: t = htm_pkg::OneQ16;
				endcase
			end
			7: t = htm_pkg::LocalW'($urandom_range(65537, 131071));
			default: t = htm_pkg::LocalW'($urandom_range(0, 65536));
		endcase
		return t;
	endfunction

	// Idle share of the phase that the next queued item falls in.
	function automatic int phase_idle();
		int ph;
		ph = cmd_q.size() * 4 / ITEM_TOTAL;
		if (ph > 3)
			ph = 3;
		return IDLE_PCT[ph];
	endfunction

	// Unused fields of each item carry random values.
	function automatic void queue_load(input logic [2:0] slot,
			input logic signed [htm_pkg::CoordW-1:0] x, y, z);
		mapper_cmd_t c;
		c.cmd = htm_pkg::CMD_LOAD;
		c.slot = slot;
		c.x = x;
		c.y = y;
		c.z = z;
		c.u = htm_pkg::LocalW'($urandom);
		c.v = htm_pkg::LocalW'($urandom);
		c.w = htm_pkg::LocalW'($urandom);
		c.idle_pct = phase_idle();
		cmd_q = {cmd_q, c};
	endfunction

	function automatic void queue_eval(input logic [htm_pkg::LocalW-1:0] u, v, w);
		mapper_cmd_t c;
		c.cmd = htm_pkg::CMD_EVAL;
		c.slot = 3'($urandom);
		c.x = $urandom;
		c.y = $urandom;
		c.z = $urandom;
		c.u = u;
		c.v = v;
		c.w = w;
		c.idle_pct = phase_idle();
		cmd_q = {cmd_q, c};
	endfunction

	// Driver: present the next pending item, hold it until the transfer.
	always @(posedge clk) begin
		mapper_cmd_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				if (command == htm_pkg::CMD_LOAD) begin
					hex_x[corner_slot] = load_x;
					hex_y[corner_slot] = load_y;
					hex_z[corner_slot] = load_z;
				end else begin
					point_q = {point_q, map_point(local_u, local_v, local_w)};
				end
			end
			if (!start || !busy) begin
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= cmd_q[0].idle_pct) begin
					nxt = cmd_q.pop_front();
					start <= 1'b1;
					command <= nxt.cmd;
					corner_slot <= nxt.slot;
					load_x <= nxt.x;
					load_y <= nxt.y;
					load_z <= nxt.z;
					local_u <= nxt.u;
					local_v <= nxt.v;
					local_w <= nxt.w;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each point against the oldest prediction.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && done) begin
			if (point_q.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h z=%h",
					$time, point_x, point_y, point_z);
				error_count++;
			end else begin
				want = point_q.pop_front();
				if (point_x !== want.x) begin
					$display("%0t: point_x expected %h actual %h", $time, want.x, point_x);
					error_count++;
				end
				if (point_y !== want.y) begin
					$display("%0t: point_y expected %h actual %h", $time, want.y, point_y);
					error_count++;
				end
				if (point_z !== want.z) begin
					$display("%0t: point_z expected %h actual %h", $time, want.z, point_z);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no transfer and no point for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int n_load;
		int n_eval;
		// evaluate on the cleared store
		queue_eval(17'd32768, 17'd12345, 17'd65536);
		// all x at the top, all y at the bottom of the range
		for (int s = 0; s < 8; s++)
			queue_load(3'(s), 32'sh7fffffff, 32'sh80000000, rand_coord());
		queue_eval(17'd0, 17'd0, 17'd0);
		queue_eval(htm_pkg::OneQ16, htm_pkg::OneQ16, htm_pkg::OneQ16);
		queue_eval(17'd131071, 17'd131071, 17'd131071);
		queue_eval(17'd65537, 17'd0, 17'd100000);
		queue_eval(17'd32768, 17'd32768, 17'd32768);
		queue_eval(17'd1, 17'd65535, 17'd12345);
		// half-LSB rounding: only corner 1 nonzero, weighted by one half
		for (int s = 0; s < 8; s++) begin
			if (s == 1)
				queue_load(3'(s), 32'sd1, -32'sd1, 32'sd3);
			else
				queue_load(3'(s), 32'sd0, 32'sd0, 32'sd0);
		end
		queue_eval(17'd32768, 17'd0, 17'd0);
		queue_eval(17'd131071, 17'd0, 17'd0);

		while (cmd_q.size() < ITEM_TOTAL) begin
			case ($urandom_range(0, 9))
				7, 8: queue_eval(rand_local(), rand_local(), rand_local());
				9: begin
					n_load = $urandom_range(1, 6);
					repeat (n_load)
						queue_load(3'($urandom), rand_coord(), rand_coord(), rand_coord());
				end
				default: begin
					// reload some or all corners, then evaluate a few points
					n_load = $urandom_range(0, 2) == 0 ? 8 : $urandom_range(1, 4);
					for (int s = 0; s < n_load; s++)
						queue_load(n_load == 8 ? 3'(s) : 3'($urandom),
							rand_coord(), rand_coord(), rand_coord());
					n_eval = $urandom_range(1, 3);
					repeat (n_eval)
						queue_eval(rand_local(), rand_local(), rand_local());
				end
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || point_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
